// ===== hdl/pstg_pkg.sv =====
// Package for the periodic sine tone generator: widths, CORDIC constants,
// arctangent table and the structs that move between the pipeline modules.
// No dependencies.
package pstg_pkg;

    // Phase resolution and CORDIC depth.
    localparam int PHASE_BITS    = 32;
    localparam int CORDIC_STAGES = 16;

    // Configuration port.
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_COUNT  = 2'd2;

    localparam logic [31:0] PHASE_STEP_RST    = 32'd42852281;
    localparam logic [15:0] PERIOD_LENGTH_RST = 16'd100;
    localparam logic [15:0] PERIOD_COUNT_RST  = 16'd880;

    // Datapath widths. x and y stay near 2^31 in magnitude; two guard bits.
    localparam int XY_W = 34;
    localparam int Z_W  = 34;
    // Residual angle after the last stage is below atan(2^-15) < 2^15.
    localparam int ZR_W = 22;
    localparam int XS_W = XY_W - 8;
    localparam int PA_W = XS_W + ZR_W;
    localparam int PB_W = PA_W + 14;
    localparam int CORR_W = PB_W - 34;
    localparam int V_W  = XY_W + 2;
    localparam int R_W  = V_W - 16;

    localparam int SMP_W = 16;
    localparam logic signed [SMP_W-1:0] AMP_MAX = 16'sd32767;
    localparam logic signed [XY_W-1:0]  X_START = 34'sd1304025951;
    localparam logic signed [13:0]      TWO_PI_Q10 = 14'sd6434;

    localparam int ATAN_IDX_W = 5;

    typedef struct packed {
        logic [1:0] quad;
        logic       period_end;
        logic       last;
        logic       active;
    } meta_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        meta_t                  meta;
    } cordic_t;

    // Arctangent of 2^-i in 2^-32 turns.
    function automatic logic signed [Z_W-1:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] a;
        begin
            case (idx)
                5'd0:    a = 32'h20000000;
                5'd1:    a = 32'h12E4051E;
                5'd2:    a = 32'h09FB385B;
                5'd3:    a = 32'h051111D4;
                5'd4:    a = 32'h028B0D43;
                5'd5:    a = 32'h0145D7E1;
                5'd6:    a = 32'h00A2F61E;
                5'd7:    a = 32'h00517C55;
                5'd8:    a = 32'h0028BE53;
                5'd9:    a = 32'h00145F2F;
                5'd10:   a = 32'h000A2F98;
                5'd11:   a = 32'h000517CC;
                5'd12:   a = 32'h00028BE6;
                5'd13:   a = 32'h000145F3;
                5'd14:   a = 32'h0000A2FA;
                5'd15:   a = 32'h0000517D;
                5'd16:   a = 32'h000028BE;
                5'd17:   a = 32'h0000145F;
                5'd18:   a = 32'h00000A30;
                5'd19:   a = 32'h00000518;
                default: a = 32'h00000000;
            endcase
            atan_turns = $signed({{(Z_W-32){1'b0}}, a});
        end
    endfunction

endpackage

// ===== hdl/pstg_if.sv =====
// Valid/ready channel interfaces for the tone generator: tick input and
// sample output. No dependencies.
interface pstg_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface pstg_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               period_end;
    logic               last;
    logic               active;

    modport source (output valid, output sample, output period_end, output last,
                    output active, input ready);
    modport sink   (input valid, input sample, input period_end, input last,
                    input active, output ready);
endinterface

// ===== hdl/periodic_sine_tone_generator.sv =====
// Top level of the periodic sine tone generator: control, CORDIC cell chain
// and output stage. Uses pstg_pkg, pstg_if, pstg_ctrl, pstg_cell, pstg_post.
//
// One tick transaction in, one sample transaction out, at one transaction per
// clock while the result side keeps up. Each accepted tick passes through one
// register in the phase/counter control, one per CORDIC cell (16 cells), two
// multiply stages for the residual-angle correction and the output register.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so tick.ready simply mirrors that; a stall on the result side
// holds every stage in place and nothing is dropped. The tone runs from reset;
// after period_count periods the samples read 0 with active low until a tick
// with restart set, whose own sample is the first of the new tone. Configuration
// writes (cfg_we, cfg_index, cfg_data) are registered and apply to the next
// tick; index 3 is ignored.
module periodic_sine_tone_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    pstg_tick_if.sink                      tick,
    pstg_sample_if.source                  result,
    input  logic                           cfg_we,
    input  logic [pstg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pstg_pkg::CFG_W-1:0]     cfg_data
);
    import pstg_pkg::*;

    // pipeline moves when the output slot is free or being drained
    logic    adv;
    logic    accept;

    cordic_t chain [0:CORDIC_STAGES];
    logic    chain_valid [0:CORDIC_STAGES];

    assign adv        = !result.valid || result.ready;
    assign tick.ready = adv;
    assign accept     = tick.valid && adv;

    pstg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .accept    (accept),
        .restart   (tick.restart),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op        (chain[0]),
        .op_valid  (chain_valid[0])
    );

    // rotation cells, one micro-rotation each
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        pstg_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .stage      (ATAN_IDX_W'(i)),
            .din        (chain[i]),
            .din_valid  (chain_valid[i]),
            .dout       (chain[i+1]),
            .dout_valid (chain_valid[i+1])
        );
    end

    pstg_post u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .din        (chain[CORDIC_STAGES]),
        .din_valid  (chain_valid[CORDIC_STAGES]),
        .sample     (result.sample),
        .period_end (result.period_end),
        .last       (result.last),
        .active     (result.active),
        .dout_valid (result.valid)
    );

endmodule

// ===== hdl/pstg_ctrl.sv =====
// Tone control: configuration registers, phase accumulator and period
// counters; launches one CORDIC operand per accepted tick. Uses pstg_pkg.
module pstg_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           accept,
    input  logic                           restart,
    input  logic                           cfg_we,
    input  logic [pstg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pstg_pkg::CFG_W-1:0]     cfg_data,
    output pstg_pkg::cordic_t              op,
    output logic                           op_valid
);
    import pstg_pkg::*;

    logic [31:0]           phase_step_reg;
    logic [15:0]           period_length_reg;
    logic [15:0]           period_count_reg;

    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [15:0]           sip_reg, sip_next;
    logic [15:0]           pdone_reg, pdone_next;
    logic                  running_reg, running_next;

    cordic_t               op_reg, op_next;
    logic                  op_valid_reg;

    logic [PHASE_BITS-1:0] phase_cur;
    logic [15:0]           sip_cur, pdone_cur;
    logic                  running_cur;
    logic [15:0]           plen_eff, pcnt_eff;
    logic                  pend, fin;
    logic [31:0]           angle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg    <= PHASE_STEP_RST;
            period_length_reg <= PERIOD_LENGTH_RST;
            period_count_reg  <= PERIOD_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PHASE_STEP:    phase_step_reg    <= cfg_data[31:0];
                REG_PERIOD_LENGTH: period_length_reg <= cfg_data[15:0];
                REG_PERIOD_COUNT:  period_count_reg  <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        // restart clears state before this tick's sample is formed
        phase_cur   = restart ? '0 : phase_reg;
        sip_cur     = restart ? '0 : sip_reg;
        pdone_cur   = restart ? '0 : pdone_reg;
        running_cur = restart | running_reg;

        plen_eff = (period_length_reg == 16'd0) ? 16'd1 : period_length_reg;
        pcnt_eff = (period_count_reg == 16'd0) ? 16'd1 : period_count_reg;

        pend = running_cur && (({1'b0, sip_cur} + 17'd1) >= {1'b0, plen_eff});
        fin  = pend && (({1'b0, pdone_cur} + 17'd1) >= {1'b0, pcnt_eff});

        angle = 32'(phase_cur) << (32 - PHASE_BITS);

        op_next.x               = X_START;
        op_next.y               = '0;
        op_next.z               = $signed({{(Z_W-30){1'b0}}, angle[29:0]});
        op_next.meta.quad       = angle[31:30];
        op_next.meta.period_end = pend;
        op_next.meta.last       = fin;
        op_next.meta.active     = running_cur;

        phase_next   = phase_cur;
        sip_next     = sip_cur;
        pdone_next   = pdone_cur;
        running_next = running_cur;
        if (running_cur)
        begin
            if (pend)
            begin
                phase_next = '0;
                sip_next   = '0;
                pdone_next = pdone_cur + 16'd1;
                if (fin)
                begin
                    running_next = 1'b0;
                end
            end
            else
            begin
                phase_next = phase_cur + phase_step_reg[PHASE_BITS-1:0];
                sip_next   = sip_cur + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            sip_reg      <= '0;
            pdone_reg    <= '0;
            running_reg  <= 1'b1;
            op_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                sip_reg     <= sip_next;
                pdone_reg   <= pdone_next;
                running_reg <= running_next;
            end
            if (adv)
            begin
                op_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg <= op_next;
        end
    end

    assign op       = op_reg;
    assign op_valid = op_valid_reg;

endmodule

// ===== hdl/pstg_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation and its pipeline
// register. Uses pstg_pkg for the operand struct and arctangent table.
module pstg_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic [pstg_pkg::ATAN_IDX_W-1:0] stage,
    input  pstg_pkg::cordic_t               din,
    input  logic                            din_valid,
    output pstg_pkg::cordic_t               dout,
    output logic                            dout_valid
);
    import pstg_pkg::*;

    cordic_t                dout_reg, dout_next;
    logic                   valid_reg;
    logic signed [XY_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  a;

    always_comb
    begin
        dx = din.y >>> stage;
        dy = din.x >>> stage;
        a  = atan_turns(stage);
        dout_next = din;
        if (!din.z[Z_W-1])
        begin
            dout_next.x = din.x - dx;
            dout_next.y = din.y + dy;
            dout_next.z = din.z - a;
        end
        else
        begin
            dout_next.x = din.x + dx;
            dout_next.y = din.y - dy;
            dout_next.z = din.z + a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= din_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout       = dout_reg;
    assign dout_valid = valid_reg;

endmodule

// ===== hdl/pstg_post.sv =====
// Residual-angle correction, quadrant select, rounding and the output
// register. Two multiply stages then the result stage. Uses pstg_pkg.
module pstg_post (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  pstg_pkg::cordic_t              din,
    input  logic                           din_valid,
    output logic signed [pstg_pkg::SMP_W-1:0] sample,
    output logic                           period_end,
    output logic                           last,
    output logic                           active,
    output logic                           dout_valid
);
    import pstg_pkg::*;

    // stage A: cross products with the residual angle
    logic signed [XY_W-1:0]   xa_reg, ya_reg;
    logic signed [PA_W-1:0]   pax_reg, pay_reg;
    meta_t                    ma_reg;
    logic                     va_reg;

    // stage B: scaled by 2*pi and floor-shifted
    logic signed [XY_W-1:0]   xb_reg, yb_reg;
    logic signed [CORR_W-1:0] cx_reg, cy_reg;
    meta_t                    mb_reg;
    logic                     vb_reg;

    // result register
    logic signed [SMP_W-1:0]  sample_reg, sample_next;
    meta_t                    mo_reg;
    logic                     vo_reg;

    logic signed [XS_W-1:0]   xs, ys;
    logic signed [ZR_W-1:0]   zr;
    logic signed [PB_W-1:0]   pbx, pby;
    logic signed [V_W-1:0]    xn, yn, v;
    logic signed [R_W-1:0]    r;
    logic signed [SMP_W-1:0]  rc;

    always_comb
    begin
        xs = XS_W'(din.x >>> 8);
        ys = XS_W'(din.y >>> 8);
        zr = ZR_W'(din.z);
        pbx = PB_W'(pax_reg) * PB_W'(TWO_PI_Q10);
        pby = PB_W'(pay_reg) * PB_W'(TWO_PI_Q10);
    end

    always_comb
    begin
        xn = V_W'(xb_reg) - V_W'(cx_reg);
        yn = V_W'(yb_reg) + V_W'(cy_reg);
        v  = mb_reg.quad[0] ? xn : yn;
        r  = R_W'((v + V_W'(32768)) >>> 16);
        if (r > R_W'(AMP_MAX))
        begin
            rc = AMP_MAX;
        end
        else if (r < -R_W'(AMP_MAX))
        begin
            rc = -AMP_MAX;
        end
        else
        begin
            rc = SMP_W'(r);
        end
        if (!mb_reg.active)
        begin
            sample_next = '0;
        end
        else if (mb_reg.quad[1])
        begin
            sample_next = -rc;
        end
        else
        begin
            sample_next = rc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= din_valid;
            vb_reg <= va_reg;
            vo_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xa_reg     <= din.x;
            ya_reg     <= din.y;
            pax_reg    <= PA_W'(ys) * PA_W'(zr);
            pay_reg    <= PA_W'(xs) * PA_W'(zr);
            ma_reg     <= din.meta;
            xb_reg     <= xa_reg;
            yb_reg     <= ya_reg;
            cx_reg     <= pbx[PB_W-1:34];
            cy_reg     <= pby[PB_W-1:34];
            mb_reg     <= ma_reg;
            sample_reg <= sample_next;
            mo_reg     <= mb_reg;
        end
    end

    assign sample     = sample_reg;
    assign period_end = mo_reg.period_end;
    assign last       = mo_reg.last;
    assign active     = mo_reg.active;
    assign dout_valid = vo_reg;

endmodule
